@@ design/cau_pkg.sv @@
package cau_pkg;

    localparam int FRAC_BITS_DEF = 8;
    localparam int DATA_W        = 16;
    localparam int QUOT_BITS     = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    localparam logic [DATA_W-1:0] SAT_POS = 16'h7fff;
    localparam logic [DATA_W-1:0] SAT_NEG = 16'h8000;

endpackage

@@ design/complex_arith_unit.sv @@
// Path from input word to output word: 3 front stages, 16 divide steps, output
// register. Throughput: one word per cycle unless the output stalls; every operation
// passes the same pipeline, one quotient bit per divide stage.
// Reset: synchronous, active low; clears all stage valid bits and the output valid.
// A stall at the output freezes the whole pipeline.
module complex_arith_unit
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]  i_s_tuser,  // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,  // res_re, res_im
    output logic [1:0]  o_m_tuser   // div_zero, saturated
);

    localparam int MAG_W = 33;
    localparam int REM_W = MAG_W + FRAC_BITS;
    localparam int CMP_W = REM_W + 32;
    localparam int NSTEP = QUOT_BITS;

    typedef struct packed {
        logic                 vld;
        logic                 dv;
        logic                 dz;
        logic                 sgn_re;
        logic                 sgn_im;
        logic                 ovf_re;
        logic                 ovf_im;
        logic [QUOT_BITS-1:0] q_re;
        logic [QUOT_BITS-1:0] q_im;
        logic [REM_W-1:0]     rem_re;
        logic [REM_W-1:0]     rem_im;
        logic [31:0]          den;
    } t_stg;

    logic w_en;

    // stage 1: products, add/sub sums
    logic               r1_vld;
    t_op                r1_op;
    logic signed [31:0] r1_rr, r1_ii, r1_ri, r1_ir, r1_bb_r, r1_bb_i;
    logic signed [16:0] r1_lin_re, r1_lin_im;

    // stage 2: numerators, denominator
    logic               r2_vld;
    t_op                r2_op;
    logic signed [33:0] r2_num_re, r2_num_im;
    logic [31:0]        r2_den;

    t_stg r_stg [0:NSTEP];
    t_stg n_stg [0:NSTEP];

    logic        r_ovld;
    logic [15:0] r_res_re, r_res_im;
    logic        r_dz, r_sat;

    logic signed [15:0] w_ar, w_ai, w_br, w_bi;
    t_op                w_op;

    assign w_en       = !r_ovld || i_m_tready;
    assign o_s_tready = w_en;
    assign w_ar = $signed(i_s_tdata[15:0]);
    assign w_ai = $signed(i_s_tdata[31:16]);
    assign w_br = $signed(i_s_tdata[47:32]);
    assign w_bi = $signed(i_s_tdata[63:48]);
    assign w_op = t_op'(i_s_tuser);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_s_tvalid;
        end
        if (w_en) begin
            r1_op   <= w_op;
            r1_rr   <= 32'(w_ar) * 32'(w_br);
            r1_ii   <= 32'(w_ai) * 32'(w_bi);
            r1_ri   <= 32'(w_ar) * 32'(w_bi);
            r1_ir   <= 32'(w_ai) * 32'(w_br);
            r1_bb_r <= 32'(w_br) * 32'(w_br);
            r1_bb_i <= 32'(w_bi) * 32'(w_bi);
            if (w_op == OP_SUB) begin
                r1_lin_re <= 17'(w_ar) - 17'(w_br);
                r1_lin_im <= 17'(w_ai) - 17'(w_bi);
            end else begin
                r1_lin_re <= 17'(w_ar) + 17'(w_br);
                r1_lin_im <= 17'(w_ai) + 17'(w_bi);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r2_op  <= r1_op;
            r2_den <= 32'(r1_bb_r) + 32'(r1_bb_i);
            case (r1_op)
                OP_MUL: begin
                    r2_num_re <= 34'(r1_rr) - 34'(r1_ii);
                    r2_num_im <= 34'(r1_ri) + 34'(r1_ir);
                end
                OP_DIV: begin
                    r2_num_re <= 34'(r1_rr) + 34'(r1_ii);
                    r2_num_im <= 34'(r1_ir) - 34'(r1_ri);
                end
                default: begin
                    r2_num_re <= 34'(r1_lin_re);
                    r2_num_im <= 34'(r1_lin_im);
                end
            endcase
        end
    end

    // stage 3: sign/magnitude, divide setup
    logic [33:0]      w_abs_re, w_abs_im;
    logic [MAG_W-1:0] w_mag_re, w_mag_im, w_m_re, w_m_im;
    logic [REM_W-1:0] w_n_re, w_n_im;

    always_comb begin
        w_abs_re = r2_num_re[33] ? 34'(-r2_num_re) : 34'(r2_num_re);
        w_abs_im = r2_num_im[33] ? 34'(-r2_num_im) : 34'(r2_num_im);
        w_mag_re = w_abs_re[MAG_W-1:0];
        w_mag_im = w_abs_im[MAG_W-1:0];
        w_m_re   = (r2_op == OP_MUL) ? (w_mag_re >> FRAC_BITS) : w_mag_re;
        w_m_im   = (r2_op == OP_MUL) ? (w_mag_im >> FRAC_BITS) : w_mag_im;
        w_n_re   = REM_W'(w_mag_re) << FRAC_BITS;
        w_n_im   = REM_W'(w_mag_im) << FRAC_BITS;

        n_stg[0]        = '0;
        n_stg[0].vld    = r2_vld;
        n_stg[0].sgn_re = r2_num_re[33];
        n_stg[0].sgn_im = r2_num_im[33];
        n_stg[0].den    = r2_den;
        if (r2_op == OP_DIV) begin
            n_stg[0].dz     = (r2_den == '0);
            n_stg[0].dv     = (r2_den != '0);
            n_stg[0].rem_re = w_n_re;
            n_stg[0].rem_im = w_n_im;
            if (r2_den != '0) begin
                n_stg[0].ovf_re = CMP_W'(w_n_re) >= (CMP_W'(r2_den) << QUOT_BITS);
                n_stg[0].ovf_im = CMP_W'(w_n_im) >= (CMP_W'(r2_den) << QUOT_BITS);
            end
        end else begin
            n_stg[0].ovf_re = |w_m_re[MAG_W-1:QUOT_BITS];
            n_stg[0].ovf_im = |w_m_im[MAG_W-1:QUOT_BITS];
            n_stg[0].q_re   = w_m_re[QUOT_BITS-1:0];
            n_stg[0].q_im   = w_m_im[QUOT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg[0].vld <= 1'b0;
        end else if (w_en) begin
            r_stg[0].vld <= n_stg[0].vld;
        end
        if (w_en) begin
            r_stg[0][$bits(t_stg)-2:0] <= n_stg[0][$bits(t_stg)-2:0];
        end
    end

    // divide steps, one quotient bit each
    for (genvar gi = 1; gi <= NSTEP; gi++) begin : g_step
        localparam int K = NSTEP - gi;
        logic [CMP_W-1:0] w_sub;
        always_comb begin
            w_sub    = CMP_W'(r_stg[gi-1].den) << K;
            n_stg[gi] = r_stg[gi-1];
            if (r_stg[gi-1].dv) begin
                if (CMP_W'(r_stg[gi-1].rem_re) >= w_sub) begin
                    n_stg[gi].rem_re  = r_stg[gi-1].rem_re - w_sub[REM_W-1:0];
                    n_stg[gi].q_re[K] = 1'b1;
                end
                if (CMP_W'(r_stg[gi-1].rem_im) >= w_sub) begin
                    n_stg[gi].rem_im  = r_stg[gi-1].rem_im - w_sub[REM_W-1:0];
                    n_stg[gi].q_im[K] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stg[gi].vld <= 1'b0;
            end else if (w_en) begin
                r_stg[gi].vld <= n_stg[gi].vld;
            end
            if (w_en) begin
                r_stg[gi][$bits(t_stg)-2:0] <= n_stg[gi][$bits(t_stg)-2:0];
            end
        end
    end

    // saturation and output register
    t_stg        w_l;
    logic        w_sat_re, w_sat_im;
    logic [15:0] w_re, w_im;

    always_comb begin
        w_l = r_stg[NSTEP];
        if (w_l.sgn_re) begin
            w_sat_re = w_l.ovf_re || (w_l.q_re > SAT_NEG);
            w_re     = w_sat_re ? SAT_NEG : 16'(-w_l.q_re);
        end else begin
            w_sat_re = w_l.ovf_re || (w_l.q_re > SAT_POS);
            w_re     = w_sat_re ? SAT_POS : w_l.q_re;
        end
        if (w_l.sgn_im) begin
            w_sat_im = w_l.ovf_im || (w_l.q_im > SAT_NEG);
            w_im     = w_sat_im ? SAT_NEG : 16'(-w_l.q_im);
        end else begin
            w_sat_im = w_l.ovf_im || (w_l.q_im > SAT_POS);
            w_im     = w_sat_im ? SAT_POS : w_l.q_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_l.vld;
        end
        if (w_en) begin
            r_res_re <= w_re;
            r_res_im <= w_im;
            r_dz     <= w_l.dz;
            r_sat    <= w_sat_re || w_sat_im;
        end
    end

    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {r_res_im, r_res_re};
    assign o_m_tuser  = {r_sat, r_dz};

endmodule

@@ design/cau_checker.sv @@
module cau_checker
    import cau_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word dropped or changed under stall");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tdata == 32'd0 && !o_m_tuser[1])
        else $error("divide by zero word not cleared");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import cau_pkg::*;

    typedef struct packed {
        logic [15:0] res_re;
        logic [15:0] res_im;
        logic        div_zero;
        logic        saturated;
    } t_result;

    class cau_scoreboard;
        t_result pending[$];
        int      n_err;

        function new();
            n_err = 0;
        endfunction

        function logic signed [15:0] clip(longint v, ref logic sat);
            if (v > 32767) begin
                sat = 1'b1;
                return 16'sh7fff;
            end
            if (v < -32768) begin
                sat = 1'b1;
                return 16'sh8000;
            end
            return v[15:0];
        endfunction

        function void note_word(t_op op, logic signed [15:0] ar, logic signed [15:0] ai,
                                logic signed [15:0] br, logic signed [15:0] bi);
            longint  re, im, den;
            longint  scale;
            logic    sat;
            t_result r;
            scale = longint'(1) << FRAC_BITS_DEF;
            sat = 1'b0;
            r.div_zero = 1'b0;
            re = 0;
            im = 0;
            case (op)
                OP_ADD: begin
                    re = longint'(ar) + br;
                    im = longint'(ai) + bi;
                end
                OP_SUB: begin
                    re = longint'(ar) - br;
                    im = longint'(ai) - bi;
                end
                OP_MUL: begin
                    re = (longint'(ar) * br - longint'(ai) * bi) / scale;
                    im = (longint'(ar) * bi + longint'(ai) * br) / scale;
                end
                default: begin
                    den = longint'(br) * br + longint'(bi) * bi;
                    if (den == 0) begin
                        r.div_zero = 1'b1;
                    end else begin
                        re = ((longint'(ar) * br + longint'(ai) * bi) * scale) / den;
                        im = ((longint'(ai) * br - longint'(ar) * bi) * scale) / den;
                    end
                end
            endcase
            r.res_re = clip(re, sat);
            r.res_im = clip(im, sat);
            r.saturated = sat;
            pending.push_back(r);
        endfunction

        function void check_word(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected word re=%h im=%h", got.res_re, got.res_im);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch exp re=%h im=%h dz=%b sat=%b got re=%h im=%h dz=%b sat=%b",
                             exp_r.res_re, exp_r.res_im, exp_r.div_zero, exp_r.saturated,
                             got.res_re, got.res_im, got.div_zero, got.saturated);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;  // a_re, a_im, b_re, b_im
    logic [1:0]  i_s_tuser;  // operation
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [31:0] o_m_tdata;  // res_re, res_im
    logic [1:0]  o_m_tuser;  // div_zero, saturated

    cau_scoreboard sb;
    bit            src_done;
    bit            hold_sink;
    bit            calm;
    int            idle_cnt;

    complex_arith_unit u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function logic [15:0] pick_val();
        case ($urandom_range(0, 9))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hffff;
            4: return 16'($urandom_range(0, 1023)) - 16'd512;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(t_op op, logic [15:0] ar, logic [15:0] ai,
                             logic [15:0] br, logic [15:0] bi);
        while (!calm && $urandom_range(0, 99) < 36) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {bi, br, ai, ar};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_word(op, ar, ai, br, bi);
    endtask

    initial begin
        t_op         op;
        logic [15:0] br, bi;
        logic [15:0] dir_v[6];
        sb = new();
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = OP_ADD;
        i_rst_n    = 1'b0;
        src_done   = 1'b0;
        calm       = 1'b0;
        hold_sink  = 1'b0;
        dir_v = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0100, 16'h0001};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 6; i++) begin
            op = t_op'(i % 4);
            send_word(op, dir_v[i], dir_v[5-i], dir_v[(i+2)%6], dir_v[(i+3)%6]);
        end
        for (int i = 0; i < 4; i++)
            send_word(t_op'(i), 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        for (int i = 0; i < 4; i++)
            send_word(t_op'(i), 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff);
        send_word(OP_DIV, 16'h1234, 16'hf00d, 16'h0000, 16'h0000);
        send_word(OP_DIV, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
        send_word(OP_DIV, 16'hff00, 16'h0080, 16'h0300, 16'h0000);
        send_word(OP_MUL, 16'hff80, 16'h0001, 16'h0080, 16'hffff);
        for (int i = 0; i < 950; i++) begin
            calm = (i >= 300 && i < 450);
            if (i == 600)
                hold_sink = 1'b1;
            op = t_op'($urandom_range(0, 3));
            br = pick_val();
            bi = pick_val();
            if (op == OP_DIV && $urandom_range(0, 15) == 0) begin
                br = '0;
                bi = '0;
            end
            send_word(op, pick_val(), pick_val(), br, bi);
        end
        calm = 1'b0;
        i_s_tvalid <= 1'b0;
        src_done = 1'b1;
    end

    // long receiver hold-off to back up the pipeline
    initial begin
        wait (hold_sink);
        repeat (200) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                sb.check_word({o_m_tdata[15:0], o_m_tdata[31:16], o_m_tuser[0], o_m_tuser[1]});
            i_m_tready <= !hold_sink && (calm || $urandom_range(0, 99) >= 36);
        end
    end

    initial begin
        idle_cnt = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (src_done && sb.pending.size() == 0) begin
                repeat (40) @(posedge i_clk);
                if (sb.n_err == 0 && sb.pending.size() == 0)
                    $display("tb: PASS");
                else
                    $display("tb: FAIL");
                $finish;
            end
            if (idle_cnt >= 2000) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

endmodule

@@ sim.f @@
design/cau_pkg.sv
design/complex_arith_unit.sv
design/cau_checker.sv
sim/tb.sv
